@@ sv/sfss_pkg.sv @@
// Shared types, constants and channel maps for the staggered fan start sequencer.
`timescale 1ns / 1ps

package sfss_pkg;

  localparam int NumUnits = 4;

  localparam logic [6:0] FullDuty = 7'd100;
  localparam logic [15:0] DefaultDelay = 16'd500;

  localparam logic [2:0] PhaseUnit4 = 3'd0;
  localparam logic [2:0] PhaseUnit3 = 3'd1;
  localparam logic [2:0] PhaseUnit2 = 3'd2;
  localparam logic [2:0] PhaseUnit1 = 3'd3;
  localparam logic [2:0] PhaseDone  = 3'd4;

  localparam logic CfgFourWireMask = 1'b0;
  localparam logic CfgStaggerDelay = 1'b1;

  typedef enum logic [2:0] {
    KindSetUnit = 3'd0,
    KindSetAll  = 3'd1,
    KindAllOn   = 3'd2,
    KindAllOff  = 3'd3,
    KindPoll    = 3'd4,
    KindRead    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  unit;
    logic [7:0]  duty_req;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [NumUnits-1:0][6:0] power;
    logic [NumUnits-1:0][6:0] ctrl;
    logic [2:0]               phase;
    logic [31:0]              last_ms;
  } fan_state_t;

  // power channel driven by unit index (unit - 1)
  function automatic logic [1:0] pwr_chan(input logic [1:0] idx);
    logic [1:0] ch;
    unique case (idx)
      2'd0: ch = 2'd1;
      2'd1: ch = 2'd0;
      2'd2: ch = 2'd3;
      2'd3: ch = 2'd2;
    endcase
    return ch;
  endfunction

  // control channel driven by unit index (unit - 1)
  function automatic logic [1:0] ctl_chan(input logic [1:0] idx);
    logic [1:0] ch;
    unique case (idx)
      2'd0: ch = 2'd0;
      2'd1: ch = 2'd3;
      2'd2: ch = 2'd2;
      2'd3: ch = 2'd1;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/staggered_fan_start_sequencer.sv @@
// Top level: staggered start and duty control for four fan units.
// Path: input register (req_q), update logic, then state and result register (state_q, rd_q).
// Throughput: one request per cycle while the result stage does not stall.
// The result stage stalls on out_ready_i; the input register then holds one request more.
// Reset (async, active low): all duties 0, phase 0, last activation 0,
// four_wire_mask 0, stagger delay 500 ms; no clearing pass.
`timescale 1ns / 1ps

module staggered_fan_start_sequencer import sfss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  unit_i,
  input  logic [7:0]  duty_req_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  power_duty_ch1_o,
  output logic [6:0]  power_duty_ch2_o,
  output logic [6:0]  power_duty_ch3_o,
  output logic [6:0]  power_duty_ch4_o,
  output logic [6:0]  ctrl_raw_ch1_o,
  output logic [6:0]  ctrl_raw_ch2_o,
  output logic [6:0]  ctrl_raw_ch3_o,
  output logic [6:0]  ctrl_raw_ch4_o,
  output logic [6:0]  read_duty_o,
  output logic [2:0]  seq_phase_o
);

  logic [NumUnits-1:0] mask_q;
  logic [15:0]         delay_q;
  req_t                req_q;
  logic                req_valid_q;
  fan_state_t          state_q, state_d;
  logic [6:0]          rd_q, rd_d;
  logic                out_valid_q;
  logic                adv;

  // result stage advances when the output slot is free or being emptied
  assign adv        = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      delay_q <= DefaultDelay;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFourWireMask: mask_q  <= cfg_wdata_i[NumUnits-1:0];
        CfgStaggerDelay: delay_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= '{kind: kind_i, unit: unit_i, duty_req: duty_req_i, now_ms: now_ms_i};
    end
  end

  sfss_update u_update (
    .st_i             (state_q),
    .req_i            (req_q),
    .four_wire_mask_i (mask_q),
    .stagger_delay_i  (delay_q),
    .st_o             (state_d),
    .read_duty_o      (rd_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q <= state_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= rd_d;
    end
  end

  // state only moves with a new result, so it doubles as the output payload
  assign out_valid_o      = out_valid_q;
  assign power_duty_ch1_o = state_q.power[0];
  assign power_duty_ch2_o = state_q.power[1];
  assign power_duty_ch3_o = state_q.power[2];
  assign power_duty_ch4_o = state_q.power[3];
  assign ctrl_raw_ch1_o   = state_q.ctrl[0];
  assign ctrl_raw_ch2_o   = state_q.ctrl[1];
  assign ctrl_raw_ch3_o   = state_q.ctrl[2];
  assign ctrl_raw_ch4_o   = state_q.ctrl[3];
  assign read_duty_o      = rd_q;
  assign seq_phase_o      = state_q.phase;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PhaseDone)
    else $error("sequence phase out of range");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.power[0] <= FullDuty) && (state_q.power[1] <= FullDuty) &&
    (state_q.power[2] <= FullDuty) && (state_q.power[3] <= FullDuty) &&
    (state_q.ctrl[0] <= FullDuty) && (state_q.ctrl[1] <= FullDuty) &&
    (state_q.ctrl[2] <= FullDuty) && (state_q.ctrl[3] <= FullDuty))
    else $error("duty above full scale");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without a request");

  a_stall_keeps_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && out_valid_q && !out_ready_i |=> req_valid_q && $stable(req_q))
    else $error("pending request lost during stall");
`endif

endmodule

@@ sv/sfss_update.sv @@
// Next-state and read logic for one fan request.
`timescale 1ns / 1ps

module sfss_update import sfss_pkg::*; (
  input  fan_state_t          st_i,
  input  req_t                req_i,
  input  logic [NumUnits-1:0] four_wire_mask_i,
  input  logic [15:0]         stagger_delay_i,
  output fan_state_t          st_o,
  output logic [6:0]          read_duty_o
);

  logic [NumUnits-1:0] en;
  logic [6:0]          duty;
  logic [6:0]          sat;
  logic                unit_ok;
  logic [1:0]          uidx;
  logic                gap_ok;

  assign sat     = (req_i.duty_req > 8'(FullDuty)) ? FullDuty : req_i.duty_req[6:0];
  assign unit_ok = (req_i.unit >= 3'd1) && (req_i.unit <= 3'(NumUnits));
  assign uidx    = 2'(req_i.unit - 3'd1);
  assign gap_ok  = (req_i.now_ms - st_i.last_ms) >= {16'd0, stagger_delay_i};

  always_comb begin
    st_o        = st_i;
    en          = '0;
    duty        = '0;
    read_duty_o = '0;
    unique case (kind_e'(req_i.kind))
      KindSetUnit: begin
        duty = sat;
        if (unit_ok) begin
          en[uidx] = 1'b1;
        end
      end
      KindSetAll: begin
        duty = sat;
        en   = '1;
      end
      KindAllOn: begin
        duty = FullDuty;
        en   = '1;
      end
      KindAllOff: begin
        duty         = '0;
        en           = '1;
        st_o.phase   = PhaseUnit4;
        st_o.last_ms = '0;
      end
      KindPoll: begin
        duty = FullDuty;
        priority if (st_i.phase == PhaseUnit4) begin
          en[3]        = 1'b1;
          st_o.last_ms = req_i.now_ms;
          st_o.phase   = PhaseUnit3;
        end else if (st_i.phase == PhaseUnit3) begin
          if (gap_ok) begin
            en[2]        = 1'b1;
            st_o.last_ms = req_i.now_ms;
            st_o.phase   = PhaseUnit2;
          end
        end else if (st_i.phase == PhaseUnit2) begin
          if (gap_ok) begin
            en[1]        = 1'b1;
            st_o.last_ms = req_i.now_ms;
            st_o.phase   = PhaseUnit1;
          end
        end else if (st_i.phase == PhaseUnit1) begin
          // last unit leaves the activation time alone
          if (gap_ok) begin
            en[0]      = 1'b1;
            st_o.phase = PhaseDone;
          end
        end else if (st_i.phase == PhaseDone) begin
          st_o.phase = PhaseDone;
        end else begin
          st_o.phase = PhaseUnit4;
        end
      end
      KindRead: begin
        if (unit_ok) begin
          read_duty_o = st_i.power[pwr_chan(uidx)];
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase

    for (int i = 0; i < NumUnits; i++) begin
      if (en[i]) begin
        if (!four_wire_mask_i[i]) begin
          st_o.power[pwr_chan(2'(i))] = duty;
        end else begin
          st_o.power[pwr_chan(2'(i))] = FullDuty;
          st_o.ctrl[ctl_chan(2'(i))]  = FullDuty - duty;
        end
      end
    end
  end

endmodule
